// ===== rtl/bdal_pkg.sv =====
// Shared types and constants for the bounded deque array list.
// Used by bdal_cell, bdal_ctrl and the top level bounded_deque_array_list.
package bdal_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OUT_CNT_W    = 9;
  localparam int COORD_W      = 8;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] sym;
  } entry_t;

  localparam entry_t DEF_ENTRY = '{x: 8'd0, y: 8'd0, sym: 8'd32};

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_REM_HEAD = 3'd2,
    REQ_REM_TAIL = 3'd3,
    REQ_RD_IDX   = 3'd4,
    REQ_RD_HEAD  = 3'd5,
    REQ_RD_TAIL  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Operation broadcast to every cell in the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,      // move one place toward tail
    OP_SHL,      // move one place toward head
    OP_WR_TAIL,  // the addressed cell takes the new entry
    OP_COPY,     // snapshot entries into the read chain
    OP_SCAN      // read chain moves one place toward head
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctl_t;

endpackage

// ===== rtl/bdal_cell.sv =====
// One storage cell of the deque chain: a stored entry plus a read-chain stage.
// Depends on bdal_pkg for entry and control types.
module bdal_cell import bdal_pkg::*; #(
  parameter int IDX_W = 8,
  parameter int POS   = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] tail_idx,
  input  entry_t           left_entry,   // neighbor toward head (new entry at cell 0)
  input  entry_t           right_entry,  // neighbor toward tail
  input  entry_t           right_shadow,
  output entry_t           entry,
  output entry_t           shadow
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  entry_t entry_r, entry_nxt;
  entry_t shadow_r, shadow_nxt;

  always_comb begin
    entry_nxt  = entry_r;
    shadow_nxt = shadow_r;
    case (ctl.op)
      OP_SHR:     entry_nxt = left_entry;
      OP_SHL:     entry_nxt = right_entry;
      OP_WR_TAIL: begin
        if (tail_idx == MY_POS) entry_nxt = ctl.new_entry;
      end
      OP_COPY:    shadow_nxt = entry_r;
      OP_SCAN:    shadow_nxt = right_shadow;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r  <= entry_nxt;
    shadow_r <= shadow_nxt;
  end

  assign entry  = entry_r;
  assign shadow = shadow_r;

endmodule

// ===== rtl/bdal_ctrl.sv =====
// Request decoder, entry counter, read-scan sequencer and output register.
// Depends on bdal_pkg; drives the cell chain through a cell_ctl_t broadcast.
module bdal_ctrl import bdal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [2:0]       in_req,
  input  logic [7:0]       in_index,
  input  entry_t           in_entry,
  output logic             out_tvalid,
  input  logic             out_tready,
  output status_t          out_status,
  output entry_t           out_entry,
  output logic [OUT_CNT_W-1:0] out_count,
  output cell_ctl_t        ctl,
  output logic [IDX_W-1:0] tail_idx,
  input  entry_t           head_entry,
  input  entry_t           head_shadow
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic               ovalid_r, ovalid_nxt;
  status_t            ostatus_r, ostatus_nxt;
  entry_t             oentry_r, oentry_nxt;
  logic [OUT_CNT_W-1:0] ocount_r, ocount_nxt;

  logic accept, full, empty, idx_bad;

  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign idx_bad   = (CMP_W'(in_index) >= CMP_W'(cnt_r));
  assign in_tready = (state_r == S_IDLE) && (!ovalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign tail_idx  = IDX_W'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    ostatus_nxt   = ostatus_r;
    oentry_nxt    = oentry_r;
    ocount_nxt    = ocount_r;
    ctl.op        = OP_HOLD;
    ctl.new_entry = in_entry;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // most requests answer at once; reset that below for a scan
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          oentry_nxt  = DEF_ENTRY;
          case (req_t'(in_req))
            REQ_INS_HEAD: begin
              if (full) ostatus_nxt = ST_FULL;
              else begin
                ctl.op  = OP_SHR;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            REQ_INS_TAIL: begin
              if (full) ostatus_nxt = ST_FULL;
              else begin
                ctl.op  = OP_WR_TAIL;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            REQ_REM_HEAD: begin
              if (empty) ostatus_nxt = ST_EMPTY;
              else begin
                ctl.op  = OP_SHL;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            REQ_REM_TAIL: begin
              if (empty) ostatus_nxt = ST_EMPTY;
              else cnt_nxt = cnt_r - 1'b1;
            end
            REQ_RD_IDX: begin
              if (idx_bad) ostatus_nxt = ST_RANGE;
              else begin
                ctl.op     = OP_COPY;
                scan_nxt   = IDX_W'(in_index);
                state_nxt  = S_SCAN;
                ovalid_nxt = 1'b0;
              end
            end
            REQ_RD_HEAD: begin
              if (empty) ostatus_nxt = ST_EMPTY;
              else oentry_nxt = head_entry;
            end
            REQ_RD_TAIL: begin
              if (empty) ostatus_nxt = ST_EMPTY;
              else begin
                ctl.op     = OP_COPY;
                scan_nxt   = IDX_W'(cnt_r - 1'b1);
                state_nxt  = S_SCAN;
                ovalid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          ocount_nxt = OUT_CNT_W'(cnt_nxt);
        end
      end
      S_SCAN: begin
        // read chain walks toward the head until the target sits in cell 0
        if (scan_r == '0) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          oentry_nxt  = head_shadow;
          ocount_nxt  = OUT_CNT_W'(cnt_r);
          state_nxt   = S_IDLE;
        end else begin
          ctl.op   = OP_SCAN;
          scan_nxt = scan_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      scan_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      scan_r   <= scan_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ostatus_r <= ostatus_nxt;
    oentry_r  <= oentry_nxt;
    ocount_r  <= ocount_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_status = ostatus_r;
  assign out_entry  = oentry_r;
  assign out_count  = ocount_r;

endmodule

// ===== rtl/bounded_deque_array_list.sv =====
// Top level of the bounded deque array list: controller plus a chain of cells.
// Depends on bdal_pkg, bdal_cell and bdal_ctrl.
//
// Usage:
//   Input stream (in_*): one request per transaction; in_tuser carries the
//   request code, in_tdata the index and the entry to insert.
//   Output stream (out_*): exactly one result per request, with status in
//   out_tuser and the read entry plus the new entry count in out_tdata.
//   Inserts, removes, head reads and failed reads give the result in the
//   cycle after acceptance. Read by index walks the read chain of the cells
//   toward the head, one cell per cycle, until the target sits in cell 0.
//   Read tail walks the same way. The walk length is set by the target
//   position: the index, or count - 1 for a tail read.
//   A single output register holds the result; a new request is accepted
//   only while it is empty or being taken, so a stalled receiver stalls the
//   input side. Reset (rst_n low, synchronous) empties the list and drops
//   any pending result; stored entries are not cleared.
module bounded_deque_array_list import bdal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // index, pos_x, pos_y, pos_symbol
  input  logic [2:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_x, out_y, out_symbol, count, zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int IDX_W = $clog2(CAPACITY);

  entry_t               in_entry;
  entry_t               out_entry;
  status_t              out_status;
  logic [OUT_CNT_W-1:0] out_count;
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     tail_idx;
  entry_t               cell_q [CAPACITY];
  entry_t               shad_q [CAPACITY];

  assign in_entry.x   = in_tdata[15:8];
  assign in_entry.y   = in_tdata[23:16];
  assign in_entry.sym = in_tdata[31:24];

  bdal_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req      (in_tuser),
    .in_index    (in_tdata[7:0]),
    .in_entry    (in_entry),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_status),
    .out_entry   (out_entry),
    .out_count   (out_count),
    .ctl         (ctl),
    .tail_idx    (tail_idx),
    .head_entry  (cell_q[0]),
    .head_shadow (shad_q[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e, right_s;
    if (i == 0) begin : g_first
      assign left_e = ctl.new_entry;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = DEF_ENTRY;
      assign right_s = DEF_ENTRY;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
      assign right_s = shad_q[i+1];
    end
    bdal_cell #(
      .IDX_W (IDX_W),
      .POS   (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .tail_idx     (tail_idx),
      .left_entry   (left_e),
      .right_entry  (right_e),
      .right_shadow (right_s),
      .entry        (cell_q[i]),
      .shadow       (shad_q[i])
    );
  end

  assign out_tuser = out_status;
  assign out_tdata = {7'd0, out_count, out_entry.sym, out_entry.y, out_entry.x};

  // a waiting result blocks new requests
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("request accepted while result stalled");

  // every request but an indexed or tail read answers in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != REQ_RD_IDX && in_tuser != REQ_RD_TAIL)
      |=> out_tvalid)
    else $error("missing single-cycle result");

  // reported count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((CAPACITY > 511) || (int'(out_count) <= CAPACITY)))
    else $error("count above capacity");

  // a failed request carries the default entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status != ST_OK) |-> (out_entry == DEF_ENTRY))
    else $error("failed request returned data");

endmodule
